/* rtl/bgran_pkg.sv */
`default_nettype none

package bgran_pkg;

    localparam logic       OP_ANALYZE = 1'b0;
    localparam logic       OP_CONVERT = 1'b1;

    localparam logic [1:0] ACT_KEEP        = 2'd0;
    localparam logic [1:0] ACT_OPAQUE      = 2'd1;
    localparam logic [1:0] ACT_PREMULTIPLY = 2'd2;

    localparam logic [31:0] COLOR_MASK = 32'h00FF_FFFF;
    localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;
    localparam logic [15:0] ROUND_BIAS = 16'd127;
    localparam logic [7:0]  ALPHA_FULL = 8'd255;

    typedef struct packed {
        logic        op;
        logic [31:0] pixel_in;
        logic        is_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        image_ok;
        logic [1:0]  action;
        logic        last_out;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/bgra_alpha_normalize_top.sv */
// BGRA alpha normaliser, streamed one pixel per transfer.
// Input channel: i_valid / o_stall with i_data (op, pixel_in, is_last).
// Output channel: o_valid / i_stall with o_data (pixel_out, image_ok,
// action, last_out).
// Analyse pixels (op 0) update three sticky flags; only the last one of the
// pass yields a result, the summary. Every convert pixel (op 1) yields one
// converted pixel; the last convert pixel clears the flags.
// Throughput: one pixel per clock, sustained while the receiver does not stall.
// A result is held first in the input register, then in the result register after
// the 8x8 multiply and divide-by-255 per channel; o_valid comes from the latter.
// Flags are updated at the input transfer, so each pixel sees the flags of
// every pixel before it.
// Reset (synchronous, active low) clears the flags and both valid bits.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, and o_stall rises only when both are full.
`default_nettype none

module bgra_alpha_normalize_top (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire bgran_pkg::t_in_item  i_data,
    output logic                      o_valid,
    input  wire                       i_stall,
    output bgran_pkg::t_out_item      o_data
);
    import bgran_pkg::*;

    function automatic logic [1:0] f_action(input logic alpha, input logic color,
                                            input logic straight);
        logic [1:0] act;
        if (!alpha && color) begin
            act = ACT_OPAQUE;
        end else if (straight) begin
            act = ACT_PREMULTIPLY;
        end else begin
            act = ACT_KEEP;
        end
        return act;
    endfunction

    // (x*a + 127) / 255, exact for sums below 2^16
    function automatic logic [7:0] f_scale(input logic [7:0] x, input logic [7:0] a);
        logic [15:0] v;
        logic [16:0] t;
        v = ({8'd0, x} * {8'd0, a}) + ROUND_BIAS;
        t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    logic r_seen_alpha, r_seen_color, r_seen_straight;
    logic n_seen_alpha, n_seen_color, n_seen_straight;

    logic        r_s1_valid, n_s1_valid;
    logic        r_s1_op;
    logic [31:0] r_s1_pixel;
    logic        r_s1_last;
    logic        r_s1_ok;
    logic [1:0]  r_s1_action;

    logic        r_o_valid, n_o_valid;
    t_out_item   r_out;

    logic        in_fire, s2_ready, s1_adv, has_result;
    logic [7:0]  in_a, in_r, in_g, in_b;
    logic        upd_alpha, upd_color, upd_straight;
    logic        s1_ok, s1_load;
    logic [1:0]  s1_action;
    logic [7:0]  s1_a;
    logic [31:0] conv_pixel;

    assign s2_ready = !r_o_valid || !i_stall;
    assign s1_adv   = r_s1_valid && s2_ready;
    assign o_stall  = r_s1_valid && !s2_ready;
    assign in_fire  = i_valid && !o_stall;

    assign in_a = i_data.pixel_in[31:24];
    assign in_r = i_data.pixel_in[23:16];
    assign in_g = i_data.pixel_in[15:8];
    assign in_b = i_data.pixel_in[7:0];

    assign upd_alpha    = r_seen_alpha || (in_a != 8'd0);
    assign upd_color    = r_seen_color || ((i_data.pixel_in & COLOR_MASK) != 32'd0);
    assign upd_straight = r_seen_straight
                       || ((in_a != 8'd0) && (in_a != ALPHA_FULL)
                           && ((in_r > in_a) || (in_g > in_a) || (in_b > in_a)));

    assign has_result = (i_data.op == OP_CONVERT) || i_data.is_last;
    assign s1_load    = in_fire && has_result;

    always_comb begin
        n_seen_alpha    = r_seen_alpha;
        n_seen_color    = r_seen_color;
        n_seen_straight = r_seen_straight;
        s1_ok           = r_seen_alpha || r_seen_color;
        s1_action       = f_action(r_seen_alpha, r_seen_color, r_seen_straight);
        if (i_data.op == OP_ANALYZE) begin
            s1_ok     = upd_alpha || upd_color;
            s1_action = f_action(upd_alpha, upd_color, upd_straight);
        end
        if (in_fire) begin
            if (i_data.op == OP_ANALYZE) begin
                n_seen_alpha    = upd_alpha;
                n_seen_color    = upd_color;
                n_seen_straight = upd_straight;
            end else if (i_data.is_last) begin
                n_seen_alpha    = 1'b0;
                n_seen_color    = 1'b0;
                n_seen_straight = 1'b0;
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_load) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (s1_adv) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    assign s1_a = r_s1_pixel[31:24];

    always_comb begin
        conv_pixel = r_s1_pixel;
        case (r_s1_action)
            ACT_OPAQUE: begin
                if ((r_s1_pixel & COLOR_MASK) != 32'd0) begin
                    conv_pixel = r_s1_pixel | ALPHA_MASK;
                end
            end
            ACT_PREMULTIPLY: begin
                if ((s1_a != 8'd0) && (s1_a != ALPHA_FULL)) begin
                    conv_pixel = {s1_a,
                                  f_scale(r_s1_pixel[23:16], s1_a),
                                  f_scale(r_s1_pixel[15:8], s1_a),
                                  f_scale(r_s1_pixel[7:0], s1_a)};
                end
            end
            default: begin
                conv_pixel = r_s1_pixel;
            end
        endcase
        if (r_s1_op == OP_ANALYZE) begin
            conv_pixel = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_alpha    <= 1'b0;
            r_seen_color    <= 1'b0;
            r_seen_straight <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            r_seen_alpha    <= n_seen_alpha;
            r_seen_color    <= n_seen_color;
            r_seen_straight <= n_seen_straight;
            r_s1_valid      <= n_s1_valid;
            r_o_valid       <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_op     <= i_data.op;
            r_s1_pixel  <= i_data.pixel_in;
            r_s1_last   <= i_data.is_last;
            r_s1_ok     <= s1_ok;
            r_s1_action <= s1_action;
        end
        if (s1_adv) begin
            r_out.pixel_out <= conv_pixel;
            r_out.image_ok  <= r_s1_ok;
            r_out.action    <= r_s1_action;
            r_out.last_out  <= r_s1_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire
